FILE: hw/rtl/bfm_pkg.sv
// bfm_pkg: shared types and constants for bulk fraction marking
// holds controller states, command and status bundles, field widths and codes
// no dependencies
package bfm_pkg;

    localparam int FRAC_W  = 17;
    localparam int LIMIT_W = 11;
    localparam int EVAL_W  = 32;
    localparam int IDX_W   = 10;
    localparam int CNTO_W  = 11;
    localparam int STAT_W  = 2;
    localparam int FRAC_SH = 16;
    localparam int MCNT_W  = 5;

    localparam logic [FRAC_W-1:0]  FRACTION_RESET = 17'd32768;
    localparam logic [FRAC_W-1:0]  FRACTION_ONE   = 17'd65536;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 11'd1025;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_QUERY   = 1'b1;

    localparam logic REG_FRACTION = 1'b0;
    localparam logic REG_LIMIT    = 1'b1;

    localparam logic [STAT_W-1:0] STAT_REFINE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_LIMIT   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOTHING = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QRY,
        S_MSTART,
        S_MUL,
        S_CHECK,
        S_SWSTART,
        S_SWEEP,
        S_DECIDE,
        S_REPORT
    } state_t;

    typedef struct packed {
        logic load;
        logic query;
        logic mul_start;
        logic mul_step;
        logic decide_init;
        logic sweep_start;
        logic decide;
        logic report;
        logic push_query;
    } cmd_t;

    typedef struct packed {
        logic mul_last;
        logic skip;
        logic sweep_busy;
        logic bit_zero;
        logic out_full;
    } sts_t;

endpackage

FILE: hw/rtl/bulk_fraction_marking.sv
// bulk fraction marking: a load beat stores one value, a query beat gets one result beat
// the summary follows the last load after a goal multiply and one memory sweep per
// threshold bit through the single read port, unless the limit is hit or nothing is stored
// one beat is worked at a time; the result register frees the input once it is taken
// rst_n is asynchronous active low: counts, totals, threshold and config go to reset values
// the value store is not cleared; reads at or above the loaded count are never used
module bulk_fraction_marking
    import bfm_pkg::*;
#(
    parameter int STORE_SIZE = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    // input beats
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [47:0]        s_tdata,   // error_value[31:0], element_index[41:32], zero pad
    input  logic               s_tuser,   // opcode
    input  logic               s_tlast,   // last_item
    // result beats
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,   // threshold[31:0], marked_count[42:32],
                                          // status[44:43], marked[45], zero pad
    output logic               m_tuser,   // answer_kind
    // register writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [FRAC_W-1:0]  cfg_data
);

    cmd_t cmd;
    sts_t sts;

    logic [FRAC_W-1:0]  fraction_reg, fraction_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic [EVAL_W-1:0]  threshold;
    logic [CNTO_W-1:0]  marked_count;
    logic [STAT_W-1:0]  status;
    logic               marked;

    // config registers, always ready
    assign cfg_ready = 1'b1;

    always_comb
    begin
        fraction_next = fraction_reg;
        limit_next    = limit_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRACTION: fraction_next = cfg_data;
                REG_LIMIT:    limit_next    = cfg_data[LIMIT_W-1:0];
                default:      fraction_next = fraction_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fraction_reg <= FRACTION_RESET;
            limit_reg    <= LIMIT_RESET;
        end
        else
        begin
            fraction_reg <= fraction_next;
            limit_reg    <= limit_next;
        end
    end

    // sequencer
    bfm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_opcode(s_tuser),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // store, multiplier, sweep and result register
    bfm_datapath #(
        .STORE_SIZE(STORE_SIZE),
        .VALUE_BITS(VALUE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .error_value  (s_tdata[31:0]),
        .element_index(s_tdata[41:32]),
        .fraction     (fraction_reg),
        .element_limit(limit_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_kind     (m_tuser),
        .out_threshold(threshold),
        .out_count    (marked_count),
        .out_status   (status),
        .out_marked   (marked)
    );

    // result beat packing
    assign m_tdata = {2'b00, marked, status, marked_count, threshold};

endmodule

FILE: hw/rtl/bfm_ram.sv
// bfm_ram: generic single write port, single read port memory
// read data is registered; no dependencies
module bfm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/bfm_ctrl.sv
// bfm_ctrl: sequencer for load, query, goal multiply and threshold bit search
// depends on bfm_pkg
module bfm_ctrl
    import bfm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_opcode,
    input  logic in_last,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   fire;

    assign in_ready = (state_reg == S_IDLE) && !sts.out_full;
    assign fire     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (fire && in_opcode == OP_QUERY)
                begin
                    state_next = S_QRY;
                end
                else if (fire && in_last)
                begin
                    state_next = S_MSTART;
                end
            end
            S_QRY:     state_next = S_IDLE;
            S_MSTART:  state_next = S_MUL;
            S_MUL:     state_next = sts.mul_last ? S_CHECK : S_MUL;
            S_CHECK:   state_next = sts.skip ? S_REPORT : S_SWSTART;
            S_SWSTART: state_next = S_SWEEP;
            S_SWEEP:   state_next = sts.sweep_busy ? S_SWEEP : S_DECIDE;
            S_DECIDE:  state_next = sts.bit_zero ? S_REPORT : S_SWSTART;
            S_REPORT:  state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load  = fire && in_opcode == OP_LOAD;
                cmd.query = fire && in_opcode == OP_QUERY;
            end
            S_QRY:     cmd.push_query  = 1'b1;
            S_MSTART:  cmd.mul_start   = 1'b1;
            S_MUL:     cmd.mul_step    = 1'b1;
            S_CHECK:   cmd.decide_init = !sts.skip;
            S_SWSTART: cmd.sweep_start = 1'b1;
            S_DECIDE:  cmd.decide      = 1'b1;
            S_REPORT:  cmd.report      = 1'b1;
            default:   cmd = '0;
        endcase
    end

endmodule

FILE: hw/rtl/bfm_datapath.sv
// bfm_datapath: value store, totals, goal multiplier, sweep accumulator and result register
// depends on bfm_pkg and bfm_ram
module bfm_datapath
    import bfm_pkg::*;
#(
    parameter int STORE_SIZE = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [EVAL_W-1:0]  error_value,
    input  logic [IDX_W-1:0]   element_index,
    input  logic [FRAC_W-1:0]  fraction,
    input  logic [LIMIT_W-1:0] element_limit,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_kind,
    output logic [EVAL_W-1:0]  out_threshold,
    output logic [CNTO_W-1:0]  out_count,
    output logic [STAT_W-1:0]  out_status,
    output logic               out_marked
);

    localparam int AW = $clog2(STORE_SIZE);
    localparam int CW = $clog2(STORE_SIZE + 1);
    localparam int SW = VALUE_BITS + CW;
    localparam int PW = SW + FRAC_W;
    localparam int GW = PW - FRAC_SH;
    localparam int BW = $clog2(VALUE_BITS);
    localparam int XW = (CW > LIMIT_W) ? CW : LIMIT_W;

    logic [CW-1:0]         n_reg, n_next;
    logic [SW-1:0]         total_reg, total_next;
    logic [VALUE_BITS-1:0] thr_reg, thr_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  closed_reg, closed_next;
    logic [PW-1:0]         macc_reg, macc_next;
    logic [PW-1:0]         mcand_reg, mcand_next;
    logic [FRAC_W-1:0]     mfr_reg, mfr_next;
    logic [MCNT_W-1:0]     mcnt_reg, mcnt_next;
    logic [VALUE_BITS-1:0] best_reg, best_next;
    logic [CW-1:0]         bcnt_reg, bcnt_next;
    logic [BW-1:0]         bitpos_reg, bitpos_next;
    logic [AW-1:0]         saddr_reg, saddr_next;
    logic                  issue_reg, issue_next;
    logic                  pvld_reg, pvld_next;
    logic [SW-1:0]         ssum_reg, ssum_next;
    logic [CW-1:0]         scnt_reg, scnt_next;
    logic                  qok_reg, qok_next;
    logic                  ov_reg, ov_next;
    logic                  okind_reg, okind_next;
    logic [EVAL_W-1:0]     othr_reg, othr_next;
    logic [CNTO_W-1:0]     ocnt_reg, ocnt_next;
    logic [STAT_W-1:0]     ostat_reg, ostat_next;
    logic                  omark_reg, omark_next;

    logic [CW-1:0]         nb;
    logic                  store_ok;
    logic [VALUE_BITS-1:0] val_in;
    logic [VALUE_BITS-1:0] rdata;
    logic [AW-1:0]         raddr;
    logic [VALUE_BITS-1:0] cand;
    logic [GW-1:0]         goal, goal_eff;
    logic [FRAC_W-1:0]     frac_clamped;
    logic                  skip;
    logic                  at_limit;
    logic [XW-1:0]         idx_x;

    assign val_in   = VALUE_BITS'(error_value);
    assign nb       = closed_reg ? '0 : n_reg;
    assign store_ok = nb < CW'(STORE_SIZE);
    assign raddr    = cmd.query ? AW'(element_index) : saddr_reg;
    assign cand     = best_reg | (VALUE_BITS'(1) << bitpos_reg);
    assign goal     = macc_reg[PW-1:FRAC_SH];
    assign goal_eff = (goal == '0) ? GW'(1) : goal;
    assign frac_clamped = (fraction > FRACTION_ONE) ? FRACTION_ONE : fraction;
    assign at_limit = XW'(n_reg) >= XW'(element_limit);
    assign skip     = at_limit || (n_reg == '0);
    assign idx_x    = XW'(element_index);

    bfm_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(STORE_SIZE)
    ) u_store (
        .clk  (clk),
        .we   (cmd.load && store_ok),
        .waddr(nb[AW-1:0]),
        .wdata(val_in),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign sts.mul_last   = mcnt_reg == MCNT_W'(FRAC_W - 1);
    assign sts.skip       = skip;
    assign sts.sweep_busy = issue_reg || pvld_reg;
    assign sts.bit_zero   = bitpos_reg == '0;
    assign sts.out_full   = ov_reg;

    always_comb
    begin
        n_next      = n_reg;
        total_next  = total_reg;
        thr_next    = thr_reg;
        cnt_next    = cnt_reg;
        closed_next = closed_reg;
        macc_next   = macc_reg;
        mcand_next  = mcand_reg;
        mfr_next    = mfr_reg;
        mcnt_next   = mcnt_reg;
        best_next   = best_reg;
        bcnt_next   = bcnt_reg;
        bitpos_next = bitpos_reg;
        saddr_next  = saddr_reg;
        issue_next  = issue_reg;
        pvld_next   = issue_reg;
        ssum_next   = ssum_reg;
        scnt_next   = scnt_reg;
        qok_next    = qok_reg;
        ov_next     = ov_reg && !out_ready;
        okind_next  = okind_reg;
        othr_next   = othr_reg;
        ocnt_next   = ocnt_reg;
        ostat_next  = ostat_reg;
        omark_next  = omark_reg;

        // load: first load after a closed batch restarts it
        if (cmd.load)
        begin
            if (closed_reg)
            begin
                closed_next = 1'b0;
                n_next      = '0;
                total_next  = '0;
                thr_next    = '0;
                cnt_next    = '0;
            end
            if (store_ok)
            begin
                n_next     = nb + CW'(1);
                total_next = (closed_reg ? '0 : total_reg) + SW'(val_in);
            end
        end

        if (cmd.query)
        begin
            qok_next = closed_reg && (cnt_reg != '0) && (idx_x < XW'(n_reg))
                       && (idx_x < XW'(STORE_SIZE));
        end

        // goal = total * fraction >> 16, shift and add one fraction bit a cycle
        if (cmd.mul_start)
        begin
            macc_next  = '0;
            mcand_next = PW'(total_reg);
            mfr_next   = frac_clamped;
            mcnt_next  = '0;
        end
        if (cmd.mul_step)
        begin
            if (mfr_reg[0])
            begin
                macc_next = macc_reg + mcand_reg;
            end
            mcand_next = mcand_reg << 1;
            mfr_next   = mfr_reg >> 1;
            mcnt_next  = mcnt_reg + MCNT_W'(1);
        end

        if (cmd.decide_init)
        begin
            best_next   = '0;
            bcnt_next   = n_reg;
            bitpos_next = BW'(VALUE_BITS - 1);
        end

        // sweep: sum and count of stored values at or above the candidate
        if (cmd.sweep_start)
        begin
            saddr_next = '0;
            issue_next = 1'b1;
            ssum_next  = '0;
            scnt_next  = '0;
        end
        if (issue_reg)
        begin
            saddr_next = saddr_reg + AW'(1);
            if (CW'(saddr_reg) == n_reg - CW'(1))
            begin
                issue_next = 1'b0;
            end
        end
        if (pvld_reg && rdata >= cand)
        begin
            ssum_next = ssum_reg + SW'(rdata);
            scnt_next = scnt_reg + CW'(1);
        end

        if (cmd.decide)
        begin
            if (GW'(ssum_reg) >= goal_eff)
            begin
                best_next = cand;
                bcnt_next = scnt_reg;
            end
            bitpos_next = bitpos_reg - BW'(1);
        end

        if (cmd.report)
        begin
            closed_next = 1'b1;
            thr_next    = skip ? '0 : best_reg;
            cnt_next    = skip ? '0 : bcnt_reg;
            ov_next     = 1'b1;
            okind_next  = KIND_SUMMARY;
            othr_next   = skip ? '0 : EVAL_W'(best_reg);
            ocnt_next   = skip ? '0 : CNTO_W'(bcnt_reg);
            omark_next  = 1'b0;
            if (at_limit)
            begin
                ostat_next = STAT_LIMIT;
            end
            else if (skip || bcnt_reg == '0)
            begin
                ostat_next = STAT_NOTHING;
            end
            else
            begin
                ostat_next = STAT_REFINE;
            end
        end

        if (cmd.push_query)
        begin
            ov_next    = 1'b1;
            okind_next = KIND_QUERY;
            othr_next  = EVAL_W'(thr_reg);
            ocnt_next  = CNTO_W'(cnt_reg);
            ostat_next = STAT_REFINE;
            omark_next = qok_reg && (rdata >= thr_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg      <= '0;
            total_reg  <= '0;
            thr_reg    <= '0;
            cnt_reg    <= '0;
            closed_reg <= 1'b0;
            issue_reg  <= 1'b0;
            pvld_reg   <= 1'b0;
            ov_reg     <= 1'b0;
            mcnt_reg   <= '0;
            bitpos_reg <= '0;
        end
        else
        begin
            n_reg      <= n_next;
            total_reg  <= total_next;
            thr_reg    <= thr_next;
            cnt_reg    <= cnt_next;
            closed_reg <= closed_next;
            issue_reg  <= issue_next;
            pvld_reg   <= pvld_next;
            ov_reg     <= ov_next;
            mcnt_reg   <= mcnt_next;
            bitpos_reg <= bitpos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        macc_reg  <= macc_next;
        mcand_reg <= mcand_next;
        mfr_reg   <= mfr_next;
        best_reg  <= best_next;
        bcnt_reg  <= bcnt_next;
        saddr_reg <= saddr_next;
        ssum_reg  <= ssum_next;
        scnt_reg  <= scnt_next;
        qok_reg   <= qok_next;
        okind_reg <= okind_next;
        othr_reg  <= othr_next;
        ocnt_reg  <= ocnt_next;
        ostat_reg <= ostat_next;
        omark_reg <= omark_next;
    end

    assign out_valid     = ov_reg;
    assign out_kind      = okind_reg;
    assign out_threshold = othr_reg;
    assign out_count     = ocnt_reg;
    assign out_status    = ostat_reg;
    assign out_marked    = omark_reg;

endmodule

FILE: verif/bulk_fraction_marking_tb.sv
// bulk_fraction_marking_tb: self-checking testbench for the bulk fraction marking block
// a scoreboard class predicts summary and query beats; plain tasks drive the streams
// depends on bfm_pkg and bulk_fraction_marking
module bulk_fraction_marking_tb;
    import bfm_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int IDLE_LIMIT  = 200000;
    localparam int SETTLE      = 10;
    localparam int CALM_FROM   = 850;     // no idling from this many beats on

    typedef struct {
        logic              kind;
        logic [EVAL_W-1:0] thr;
        logic [CNTO_W-1:0] cnt;
        logic [STAT_W-1:0] stat;
        logic              mark;
    } answer_t;

    // predicts the marking block beat by beat and holds the answers still due
    class marking_scoreboard;
        logic [EVAL_W-1:0]  values[STORE_DEPTH];
        int unsigned        nloaded;
        logic [63:0]        total;   // 1024 32-bit values never exceed 64 bits
        logic [EVAL_W-1:0]  thr_reg;
        logic [CNTO_W-1:0]  cnt_reg;
        bit                 closed;
        logic [FRAC_W-1:0]  frac;
        logic [LIMIT_W-1:0] limit;
        answer_t            due[$];
        int                 errors;

        function new();
            nloaded = 0;
            total   = 0;
            thr_reg = 0;
            cnt_reg = 0;
            closed  = 0;
            frac    = FRACTION_RESET;
            limit   = LIMIT_RESET;
            errors  = 0;
        endfunction

        function void write_reg(logic idx, logic [FRAC_W-1:0] data);
            if (idx == REG_FRACTION)
                frac = data;
            else
                limit = data[LIMIT_W-1:0];
        endfunction

        // threshold selection over the stored values, returns status
        function logic [STAT_W-1:0] select_threshold();
            logic [EVAL_W-1:0] sorted[$];
            logic [63:0]       goal;
            logic [63:0]       prefix;
            logic [FRAC_W-1:0] f;
            int unsigned       c;
            if (nloaded >= limit || nloaded == 0)
            begin
                thr_reg = 0;
                cnt_reg = 0;
                return (nloaded >= limit) ? STAT_LIMIT : STAT_NOTHING;
            end
            f = (frac > FRACTION_ONE) ? FRACTION_ONE : frac;
            goal = (total >> 16) * f + (((total & 64'hFFFF) * f) >> 16);
            for (int i = 0; i < nloaded; i++)
                sorted.push_back(values[i]);
            sorted.rsort();
            thr_reg = sorted[nloaded-1];
            prefix = 0;
            for (int i = 0; i < nloaded; i++)
            begin
                prefix += sorted[i];
                if (prefix >= goal)
                begin
                    thr_reg = sorted[i];
                    break;
                end
            end
            c = 0;
            for (int i = 0; i < nloaded; i++)
                if (values[i] >= thr_reg)
                    c++;
            cnt_reg = CNTO_W'(c);
            return (c == 0) ? STAT_NOTHING : STAT_REFINE;
        endfunction

        function void note_input(logic op, logic [EVAL_W-1:0] val, logic last,
                                 logic [IDX_W-1:0] idx);
            answer_t a;
            if (op == OP_LOAD)
            begin
                if (closed)
                begin
                    closed  = 0;
                    nloaded = 0;
                    total   = 0;
                    thr_reg = 0;
                    cnt_reg = 0;
                end
                // a full store drops further values
                if (nloaded < STORE_DEPTH)
                begin
                    values[nloaded] = val;
                    nloaded++;
                    total += val;
                end
                if (!last)
                    return;
                a.stat   = select_threshold();
                closed   = 1;
                a.kind   = KIND_SUMMARY;
                a.thr    = thr_reg;
                a.cnt    = cnt_reg;
                a.mark   = 0;
                due.push_back(a);
            end
            else
            begin
                a.kind = KIND_QUERY;
                a.thr  = thr_reg;
                a.cnt  = cnt_reg;
                a.stat = 0;
                a.mark = closed && cnt_reg != 0 && idx < nloaded && values[idx] >= thr_reg;
                due.push_back(a);
            end
        endfunction

        function void check_result(logic kind, logic [EVAL_W-1:0] thr,
                                   logic [CNTO_W-1:0] cnt, logic [STAT_W-1:0] stat,
                                   logic mark);
            answer_t a;
            if (due.size() == 0)
            begin
                $error("unexpected result beat");
                errors++;
                return;
            end
            a = due.pop_front();
            if (kind !== a.kind)
            begin
                $error("answer_kind expected %0d actual %0d", a.kind, kind);
                errors++;
            end
            if (thr !== a.thr)
            begin
                $error("threshold expected %0h actual %0h", a.thr, thr);
                errors++;
            end
            if (cnt !== a.cnt)
            begin
                $error("marked_count expected %0d actual %0d", a.cnt, cnt);
                errors++;
            end
            if (stat !== a.stat)
            begin
                $error("status expected %0d actual %0d", a.stat, stat);
                errors++;
            end
            if (mark !== a.mark)
            begin
                $error("marked expected %0d actual %0d", a.mark, mark);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 0;
    logic              rst_n = 0;
    logic              s_tvalid = 0;
    logic              s_tready;
    logic [47:0]       s_tdata = '0;   // error_value[31:0], element_index[41:32], zero pad
    logic              s_tuser = 0;    // opcode
    logic              s_tlast = 0;    // last_item
    logic              m_tvalid;
    logic              m_tready = 0;
    logic [47:0]       m_tdata;        // threshold[31:0], marked_count[42:32],
                                       // status[44:43], marked[45], zero pad
    logic              m_tuser;        // answer_kind
    logic              cfg_valid = 0;
    logic              cfg_ready;
    logic              cfg_index = 0;
    logic [FRAC_W-1:0] cfg_data = '0;

    marking_scoreboard sb = new();
    bit idle_on = 1;       // random idling on both sides, cleared for the final stretch
    int items = 0;
    int idle_cycles = 0;
    int stall_left = 0;

    bulk_fraction_marking dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // receiver: ready with random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 0;
        end
        else if (idle_on && rst_n && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 12) - 1;
            m_tready <= 0;
        end
        else
        begin
            m_tready <= 1;
        end
    end

    // result monitor and watchdog on cycles with no beat moving anywhere
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[31:0], m_tdata[42:32], m_tdata[44:43],
                            m_tdata[45]);
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready)
            || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("bulk_fraction_marking_tb: errors");
            $finish;
        end
    end

    // one input beat, with an optional random gap in front of it
    task automatic send_beat(logic op, logic [EVAL_W-1:0] val, logic last,
                             logic [IDX_W-1:0] idx);
        if (items >= CALM_FROM)
            idle_on = 0;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {6'd0, idx, val};
        do @(posedge clk); while (!s_tready);
        sb.note_input(op, val, last, idx);
        items++;
    endtask

    task automatic end_stream();
        s_tvalid <= 0;
        s_tlast  <= 0;
    endtask

    // pause the sender until every answer is back, then let the block settle
    task automatic drain();
        end_stream();
        @(posedge clk);
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [FRAC_W-1:0] data);
        drain();
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    function automatic logic [EVAL_W-1:0] rand_value();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 15);          // small values give ties
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic load_batch(int n);
        for (int i = 0; i < n; i++)
            send_beat(OP_LOAD, rand_value(), i == n - 1, IDX_W'($urandom_range(0, 1023)));
    endtask

    initial
    begin
        int n;
        bit filled;
        filled = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: queries before any batch, extremes, goal zero, fraction above one,
        // element limit reached, query while a batch is open
        send_beat(OP_QUERY, 32'hFFFF_FFFF, 1, 10'd0);
        send_beat(OP_QUERY, 32'd0, 0, 10'd1023);
        send_beat(OP_LOAD, 32'hFFFF_FFFF, 0, 10'd1023);
        send_beat(OP_LOAD, 32'd0, 0, 10'd0);
        send_beat(OP_LOAD, 32'd1, 1, 10'd0);
        for (int i = 0; i < 4; i++)
            send_beat(OP_QUERY, $urandom, 1'($urandom_range(0, 1)), i[IDX_W-1:0]);
        send_beat(OP_QUERY, 32'd0, 0, 10'd1023);
        write_reg(REG_FRACTION, 17'd0);
        send_beat(OP_LOAD, 32'd5, 0, 10'd0);
        send_beat(OP_LOAD, 32'd9, 0, 10'd0);
        send_beat(OP_LOAD, 32'd3, 1, 10'd0);
        send_beat(OP_QUERY, 32'd0, 0, 10'd1);
        write_reg(REG_FRACTION, FRACTION_ONE);
        load_batch(3);
        write_reg(REG_FRACTION, 17'h1FFFF);
        load_batch(3);
        write_reg(REG_LIMIT, 17'd2);
        load_batch(2);
        send_beat(OP_QUERY, 32'd0, 0, 10'd0);
        write_reg(REG_LIMIT, 17'd0);
        load_batch(1);
        write_reg(REG_LIMIT, 17'd2047);
        send_beat(OP_LOAD, 32'd0, 0, 10'd0);
        send_beat(OP_QUERY, 32'd0, 0, 10'd0);
        send_beat(OP_LOAD, 32'd0, 1, 10'd0);

        // random batches with queries, config changes in between
        while (items < 1000)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: write_reg(REG_FRACTION, FRAC_W'($urandom_range(0, 131071)));
                    1: write_reg(REG_FRACTION, FRAC_W'($urandom_range(0, 65536)));
                    2: write_reg(REG_LIMIT, FRAC_W'($urandom_range(0, 12)));
                    default: write_reg(REG_LIMIT, $urandom_range(0, 1) ? FRAC_W'(LIMIT_RESET)
                                                   : FRAC_W'($urandom_range(0, 2047)));
                endcase
            end
            if (!filled && items > 150)
            begin
                // fill the store past its depth once with no limit in the way
                filled = 1;
                write_reg(REG_LIMIT, 17'd2047);
                load_batch(STORE_DEPTH + 4);
            end
            n = ($urandom_range(0, 40) == 0) ? $urandom_range(20, 150)
                                             : $urandom_range(1, 12);
            if ($urandom_range(0, 7) == 0)
            begin
                // noise: a query inside an open batch
                send_beat(OP_LOAD, rand_value(), 0, IDX_W'($urandom));
                send_beat(OP_QUERY, $urandom, 1'($urandom_range(0, 1)), IDX_W'($urandom));
            end
            load_batch(n);
            repeat ($urandom_range(0, 4))
                send_beat(OP_QUERY, $urandom, 1'($urandom_range(0, 1)),
                          $urandom_range(0, 1) ? IDX_W'($urandom_range(0, n + 1))
                                               : IDX_W'($urandom));
        end
        end_stream();

        @(posedge clk);
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("bulk_fraction_marking_tb: clean");
        else
            $display("bulk_fraction_marking_tb: errors");
        $finish;
    end

endmodule
